// ===== rtl/nla_pkg.sv =====
// Shared types and constants for the natural logarithm approximation block.
// Holds the fixed-point widths and the Q.24 polynomial coefficients.
// No dependencies.
package nla_pkg;

    localparam int VAL_W    = 32;  // input operand width
    localparam int OUT_W    = 21;  // result width, signed
    localparam int INT_FRAC = 24;  // internal fraction bits
    localparam int X_W      = INT_FRAC + 1;          // normalised operand, unsigned Q1.24
    localparam int E_W      = 5;                     // exponent, at most VAL_W - FRAC_BITS - 1
    localparam int SH_W     = 6;                     // normalising shift amount
    localparam int ACC_W    = 28;                    // Horner accumulator, signed Q.24
    localparam int P_W      = ACC_W + X_W + 1;       // accumulator times operand
    localparam int FL_W     = P_W - INT_FRAC;        // product scaled back to Q.24
    localparam int ELN_W    = 28;                    // exponent times ln2
    localparam int R_W      = 30;                    // sum before rounding

    localparam logic signed [ACC_W-1:0] C0 = -28'sd29222452;
    localparam logic signed [ACC_W-1:0] C1 = 28'sd47331925;
    localparam logic signed [ACC_W-1:0] C2 = -28'sd24661783;
    localparam logic signed [ACC_W-1:0] C3 = 28'sd7502428;
    localparam logic signed [ACC_W-1:0] C4 = 28'sd949101;
    localparam logic [ELN_W-1:0]        LN2_Q = 28'd11629080;

    localparam logic signed [R_W+1:0] OUT_MAX = 32'sd1048575;
    localparam logic signed [R_W+1:0] OUT_MIN = -32'sd1048576;

    typedef logic [X_W-1:0]          t_x;
    typedef logic [E_W-1:0]          t_exp;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [P_W-1:0]   t_prod;

    // Normaliser output: mantissa and exponent travel together.
    typedef struct packed {
        t_x   x;
        t_exp e;
    } t_norm;

endpackage

// ===== rtl/nla_in_if.sv =====
// Input channel of the natural logarithm block: valid, ready and the operand.
// Depends on nla_pkg for the payload width.
interface nla_in_if;
    logic                      valid;
    logic                      ready;
    logic [nla_pkg::VAL_W-1:0] value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

// ===== rtl/nla_out_if.sv =====
// Result channel of the natural logarithm block: valid, ready and the log value.
// Depends on nla_pkg for the payload width.
interface nla_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [nla_pkg::OUT_W-1:0] log_out;

    modport source (output valid, output log_out, input ready);
    modport sink   (input valid, input log_out, output ready);
endinterface

// ===== rtl/natural_log_approx.sv =====
// Top level of the natural logarithm approximation pipeline.
// Depends on nla_pkg, nla_in_if, nla_out_if, nla_norm and nla_mac.
//
// Usage:
//   i_in carries an unsigned Q(32-FRAC_BITS).FRAC_BITS operand in value_in; a beat
//   is taken when valid and ready are both high. o_out returns one signed
//   Q.FRAC_BITS result in log_out for every input beat, in order.
//   Pipeline: normalise, C4 product, three Horner multiply steps, final add of
//   e*ln2, then rounding and saturation into the output register.
//   o_out.valid is the valid bit of the last stage, so a result beat leaves only
//   after its input has passed through all seven register stages. The block
//   takes one beat per cycle while i_in.ready is high; that rate is set by the
//   seven register stages, so a new beat enters before the last one is through.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles close up while the receiver stalls. i_in.ready falls only when all
//   seven stages hold data and o_out.ready is low; nothing is lost or repeated.
//   Synchronous reset clears all valid bits; the data registers are not reset.
//   A zero operand returns the constant term, about -1.742.
module natural_log_approx #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nla_in_if.sink    i_in,
    nla_out_if.source o_out
);
    import nla_pkg::*;

    localparam int NSTG   = 7;
    localparam int RND_SH = INT_FRAC - FRAC_BITS;
    localparam logic signed [R_W+1:0] RND_ONE = (R_W + 2)'(1) << RND_SH;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;

    t_norm              norm;
    t_x                 r_x1, r_x2, r_x3, r_x4;
    t_exp               r_e1;
    logic [ELN_W-1:0]   r_eln2, r_eln3, r_eln4, r_eln5;
    t_prod              r_p2, r_p3, r_p4, r_p5;
    t_prod              n_p3, n_p4, n_p5;
    logic signed [R_W-1:0]   r_r6, n_r6;
    logic signed [OUT_W-1:0] r_out, n_out;
    logic signed [FL_W-1:0]  fl5;
    logic signed [R_W+1:0]   biased, q;

    // Stage enables: a stage may load when it is empty or its successor moves.
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    nla_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_value (i_in.value_in),
        .o_norm  (norm)
    );

    nla_mac u_mac3 (.i_prod(r_p2), .i_coef(C3), .i_sub(1'b1), .i_x(r_x2), .o_prod(n_p3));
    nla_mac u_mac4 (.i_prod(r_p3), .i_coef(C2), .i_sub(1'b0), .i_x(r_x3), .o_prod(n_p4));
    nla_mac u_mac5 (.i_prod(r_p4), .i_coef(C1), .i_sub(1'b0), .i_x(r_x4), .o_prod(n_p5));

    always_comb begin
        fl5  = $signed(r_p5[P_W-1:INT_FRAC]);
        n_r6 = R_W'(fl5) + R_W'(C0) + $signed({2'b00, r_eln5});

        // Half-up rounding with one extra low bit, which also covers a zero shift.
        biased = $signed({r_r6[R_W-1], r_r6, 1'b0}) + RND_ONE;
        q      = biased >>> (RND_SH + 1);
        priority if (q > OUT_MAX) begin
            n_out = OUT_MAX[OUT_W-1:0];
        end else if (q < OUT_MIN) begin
            n_out = OUT_MIN[OUT_W-1:0];
        end else begin
            n_out = q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x1 <= norm.x;
            r_e1 <= norm.e;
        end
        if (en[1]) begin
            r_p2   <= C4 * $signed({1'b0, r_x1});
            r_x2   <= r_x1;
            r_eln2 <= ELN_W'(r_e1) * LN2_Q;
        end
        if (en[2]) begin
            r_p3   <= n_p3;
            r_x3   <= r_x2;
            r_eln3 <= r_eln2;
        end
        if (en[3]) begin
            r_p4   <= n_p4;
            r_x4   <= r_x3;
            r_eln4 <= r_eln3;
        end
        if (en[4]) begin
            r_p5   <= n_p5;
            r_eln5 <= r_eln4;
        end
        if (en[5]) begin
            r_r6 <= n_r6;
        end
        if (en[6]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_v[NSTG-1];
    assign o_out.log_out = r_out;

    // The input side may only stall when every stage is occupied.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v))
        else $error("input stalled with an empty pipeline stage");

    // A non-zero exponent must leave the operand normalised into [1,2).
    a_norm_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && (r_e1 != '0)) |-> r_x1[X_W-1])
        else $error("normalised operand lost its leading one");

    // An operand below one keeps a zero exponent.
    a_small_exp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.value_in[VAL_W-1:FRAC_BITS] == '0))
        |=> (r_e1 == '0))
        else $error("exponent set for an operand below one");

endmodule

// ===== rtl/nla_norm.sv =====
// Normaliser: finds the leading one of the integer part and scales the
// operand to unsigned Q1.24. Depends on nla_pkg.
module nla_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic [nla_pkg::VAL_W-1:0] i_value,
    output nla_pkg::t_norm            o_norm
);
    import nla_pkg::*;

    localparam int IP_W = VAL_W - FRAC_BITS;

    logic [IP_W-1:0]           ipart;
    t_exp                      e;
    logic [SH_W-1:0]           shift;
    logic [VAL_W+INT_FRAC-1:0] wide;

    always_comb begin
        ipart = i_value[VAL_W-1:FRAC_BITS];
        e     = '0;
        for (int i = 0; i < IP_W; i++) begin
            if (ipart[i]) begin
                e = E_W'(i);
            end
        end
        // Shifting the operand, padded with 24 zero bits, right by FRAC_BITS + e
        // covers both the left and the right shift with truncation.
        shift = SH_W'(FRAC_BITS) + SH_W'(e);
        wide  = {i_value, INT_FRAC'(0)} >> shift;
        o_norm.x = wide[X_W-1:0];
        o_norm.e = e;
    end

endmodule

// ===== rtl/nla_mac.sv =====
// One Horner step: rescales the previous product with floor, adds or subtracts
// it from a coefficient and multiplies the result by the operand. Depends on nla_pkg.
module nla_mac (
    input  nla_pkg::t_prod i_prod,
    input  nla_pkg::t_acc  i_coef,
    input  logic           i_sub,
    input  nla_pkg::t_x    i_x,
    output nla_pkg::t_prod o_prod
);
    import nla_pkg::*;

    logic signed [FL_W-1:0] fl;
    logic signed [FL_W-1:0] sum;
    t_acc                   acc;

    always_comb begin
        // Dropping the low bits of a two's complement product rounds towards minus infinity.
        fl  = $signed(i_prod[P_W-1:INT_FRAC]);
        sum = i_sub ? (FL_W'(i_coef) - fl) : (FL_W'(i_coef) + fl);
        acc = sum[ACC_W-1:0];
        o_prod = acc * $signed({1'b0, i_x});
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for natural_log_approx: drives operands, predicts each log result.
// Depends on nla_pkg, nla_in_if, nla_out_if and the natural_log_approx RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOG_FRAC     = 16;
    localparam int Q_FRAC       = 24;
    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 1830;
    localparam int STEADY_COUNT = 250;
    localparam int HOLD_CYCLES  = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // Polynomial terms and ln2, signed Q.24.
    localparam longint K0   = -64'sd29222452;
    localparam longint K1   = 64'sd47331925;
    localparam longint K2   = -64'sd24661783;
    localparam longint K3   = 64'sd7502428;
    localparam longint K4   = 64'sd949101;
    localparam longint KLN2 = 64'sd11629080;
    localparam longint LOG_MAX = 64'sd1048575;
    localparam longint LOG_MIN = -64'sd1048576;

    typedef logic [nla_pkg::VAL_W-1:0]        t_operand;
    typedef logic signed [nla_pkg::OUT_W-1:0] t_log;

    class ln_scoreboard;
        t_log        pending_logs[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function t_log predict_log(t_operand y);
            longint yl;
            longint ipart;
            longint x;
            longint acc;
            longint r;
            longint e;
            int     s;
            int     i;
            yl    = longint'({32'b0, y});
            ipart = yl >> LOG_FRAC;
            e     = 0;
            for (i = 0; i < 32; i++)
                if (ipart[i]) e = i;
            s = LOG_FRAC + int'(e);
            if (s > Q_FRAC)
                x = yl >> (s - Q_FRAC);
            else
                x = yl << (Q_FRAC - s);
            // Arithmetic shifts on signed products floor towards minus infinity.
            acc = K3 - ((K4 * x) >>> Q_FRAC);
            acc = K2 + ((acc * x) >>> Q_FRAC);
            acc = K1 + ((acc * x) >>> Q_FRAC);
            acc = K0 + ((acc * x) >>> Q_FRAC);
            r   = acc + e * KLN2;
            r   = (r + (64'sd1 <<< (Q_FRAC - LOG_FRAC - 1))) >>> (Q_FRAC - LOG_FRAC);
            if (r > LOG_MAX) r = LOG_MAX;
            if (r < LOG_MIN) r = LOG_MIN;
            return t_log'(r[nla_pkg::OUT_W-1:0]);
        endfunction

        function void note_operand(t_operand y);
            pending_logs.push_back(predict_log(y));
        endfunction

        function void check_log(t_log got);
            t_log want;
            if (pending_logs.size() == 0) begin
                $error("log_out: no result expected, got %0d", got);
                errors++;
            end else begin
                want = pending_logs.pop_front();
                if (got !== want) begin
                    $error("log_out: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic hold_request;
    logic steady_tail;
    int   quiet_cycles = 0;

    ln_scoreboard sb;

    nla_in_if  in_if ();
    nla_out_if out_if ();

    natural_log_approx #(
        .FRAC_BITS(LOG_FRAC)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result beats are checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_log(out_if.log_out);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none at the tail.
    initial begin
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (steady_tail) begin
                out_if.ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
        end
    end

    task automatic push_operand(input t_operand v);
        in_if.valid    <= 1'b1;
        in_if.value_in <= v;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_operand(v);
    endtask

    task automatic sender_gap();
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    function automatic t_operand pick_operand();
        t_operand v;
        int       k;
        k = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: begin
                // Leading one placed at a chosen exponent, random bits below it.
                v = (t_operand'(1) << (LOG_FRAC + k))
                    | (t_operand'($urandom) & ((t_operand'(1) << (LOG_FRAC + k)) - 1));
            end
            7: v = $urandom_range(0, 16'hFFFF);
            8: v = $urandom_range(0, 255);
            default: v = (t_operand'(1) << $urandom_range(0, 31)) - $urandom_range(0, 1);
        endcase
        return v;
    endfunction

    initial begin
        t_operand corner_values [N_DIRECTED];
        int       n;

        corner_values = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_8000,
                          32'h0000_FFFF, 32'h0001_0000, 32'h0001_0001, 32'h0001_7FFF,
                          32'h0001_8000, 32'h0001_FFFF, 32'h0002_0000, 32'h0002_FFFF,
                          32'h0003_0000, 32'h0008_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'h00FF_00FF, 32'h0100_0000};
        sb             = new();
        hold_request   = 1'b0;
        steady_tail    = 1'b0;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.value_in <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_values[j]) begin
            push_operand(corner_values[j]);
            if ($urandom_range(0, 3) == 0) sender_gap();
        end

        for (n = 0; n < N_RANDOM; n++) begin
            // Back-to-back beats against a long receiver hold-off fill the pipeline.
            if (n == 300 || n == 1200) hold_request = 1'b1;
            if (n == N_RANDOM - STEADY_COUNT) steady_tail = 1'b1;
            push_operand(pick_operand());
            if (!steady_tail && !hold_request && $urandom_range(0, 7) == 0)
                sender_gap();
        end
        in_if.valid <= 1'b0;

        while (sb.pending_logs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
